// ===== sv/xbs_pkg.sv =====
package xbs_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } t_state;

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_WAIT_BLOCK,
        PH_WAIT_EOT
    } t_phase;

    localparam logic [1:0] CMD_PAYLOAD = 2'd0;
    localparam logic [1:0] CMD_LINK    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;
    localparam logic [1:0] CMD_FINISH  = 2'd3;

    localparam logic [2:0] STAT_WORKING  = 3'd0;
    localparam logic [2:0] STAT_ACKED    = 3'd1;
    localparam logic [2:0] STAT_FINISHED = 3'd2;
    localparam logic [2:0] STAT_REJECTED = 3'd3;
    localparam logic [2:0] STAT_NO_RESP  = 3'd4;
    localparam logic [2:0] STAT_IGNORED  = 3'd5;

    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;

    localparam logic REG_MAX_ATTEMPTS = 1'b0;
    localparam logic REG_PAUSE_FROM   = 1'b1;

    localparam logic [7:0] MAX_ATTEMPTS_RST = 8'd16;
    localparam logic [7:0] PAUSE_FROM_RST   = 8'd7;
    localparam logic [7:0] SEQ_START        = 8'd1;

endpackage

// ===== sv/xbs_in_if.sv =====
interface xbs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] payload_byte;
    logic       section_end;
    logic       console_mode;
    logic [7:0] link_byte;

    modport source (output valid, command, payload_byte, section_end, console_mode,
                    link_byte, input ready);
    modport sink (input valid, command, payload_byte, section_end, console_mode,
                  link_byte, output ready);
endinterface

// ===== sv/xbs_out_if.sv =====
interface xbs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] tx_word;
    logic [2:0]  tx_count;
    logic        pause_before;
    logic        console_valid;
    logic [7:0]  console_byte;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, tx_word, tx_count, pause_before, console_valid,
                    console_byte, status, last, input ready);
    modport sink (input valid, tx_word, tx_count, pause_before, console_valid,
                  console_byte, status, last, output ready);
endinterface

// ===== sv/xbs_store.sv =====
module xbs_store #(
    parameter int WORDS = 33,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic [1:0]          i_wlane,
    input  logic [7:0]          i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output logic [3:0][7:0]     o_rdata
);

    // one word per four frame positions, data bytes already at their frame lane
    logic [3:0][7:0] r_mem [WORDS];
    logic [3:0][7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][i_wlane] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/xmodem_block_sender.sv =====
// XMODEM block sender.
// i_req carries one request per handshake: a payload byte, a received link
// byte, a receive timeout or a finish command. o_res returns the results,
// each with up to four link bytes in tx_word (first byte in bits 7:0), and
// last marks the final result of a request.
// Configuration (attempt limit, pause threshold) is written through
// i_cfg_we / i_cfg_index / i_cfg_data while the block is idle; the user must ensure this.
// A request with one result: the result sits in the output register in the
// cycle after acceptance, and the next request is taken at once if the
// receiver takes that result in the same cycle.
// A frame: payload bytes sit in a frame store with one write and one read
// port, laid out by frame position; each of the (BLOCK_BYTES+7)/4 words is
// read from the store (ST_READ) and then loaded into the output register
// (ST_SEND), which waits while the output register is held. No request is
// taken while a frame goes out.
// When the receiver stalls, the output register holds and the sequencer
// waits. Reset empties the block, sets the sequence number to 1 and
// restores the register defaults; the frame store is not cleared.
module xmodem_block_sender #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    xbs_in_if.sink       i_req,
    xbs_out_if.source    o_res,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    localparam int TOTAL    = BLOCK_BYTES + 4;
    localparam int WORDS    = (TOTAL + 3) / 4;
    localparam int AW       = $clog2(WORDS);
    localparam int PW       = AW + 2;
    localparam int FW       = $clog2(BLOCK_BYTES + 1);
    localparam int CNT_LAST = TOTAL - 4 * (WORDS - 1);

    xbs_pkg::t_state r_state, n_state;
    xbs_pkg::t_phase r_phase, n_phase;
    logic [FW-1:0]   r_fill, n_fill;
    logic [7:0]      r_seq, n_seq;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      r_att, n_att;
    logic            r_bcons, n_bcons;
    logic [AW-1:0]   r_wcnt, n_wcnt;
    logic [7:0]      r_max_att;
    logic [7:0]      r_pause_from;

    logic            r_out_valid, n_out_valid;
    logic [31:0]     r_tx_word, n_tx_word;
    logic [2:0]      r_tx_count, n_tx_count;
    logic            r_pause, n_pause;
    logic            r_cv, n_cv;
    logic [7:0]      r_cb, n_cb;
    logic [2:0]      r_status, n_status;
    logic            r_last, n_last;

    logic            mem_we;
    logic            mem_re;
    logic [PW-1:0]   wpos;
    logic [3:0][7:0] mem_rdata;
    logic [3:0][7:0] frame_word;

    logic            out_free;
    logic            acc;

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == xbs_pkg::ST_IDLE) && out_free;
    assign acc         = i_req.valid && i_req.ready;
    assign wpos        = PW'(r_fill) + PW'(3);
    assign mem_re      = (r_state == xbs_pkg::ST_READ);

    xbs_store #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(wpos >> 2)),
        .i_wlane (wpos[1:0]),
        .i_wdata (i_req.payload_byte),
        .i_re    (mem_re),
        .i_raddr (r_wcnt),
        .o_rdata (mem_rdata)
    );

    // patch header, checksum and unfilled lanes into the word read from the store
    always_comb begin
        logic [PW-1:0] pos;
        for (int l = 0; l < 4; l++) begin
            pos = {r_wcnt, 2'(l)};
            if (pos == PW'(0)) begin
                frame_word[l] = xbs_pkg::BYTE_SOH;
            end else if (pos == PW'(1)) begin
                frame_word[l] = r_seq;
            end else if (pos == PW'(2)) begin
                frame_word[l] = ~r_seq;
            end else if (pos == PW'(BLOCK_BYTES + 3)) begin
                frame_word[l] = r_sum;
            end else if (pos < PW'(r_fill) + PW'(3)) begin
                frame_word[l] = mem_rdata[l];
            end else begin
                frame_word[l] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att    <= xbs_pkg::MAX_ATTEMPTS_RST;
            r_pause_from <= xbs_pkg::PAUSE_FROM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                xbs_pkg::REG_MAX_ATTEMPTS: r_max_att    <= i_cfg_data;
                xbs_pkg::REG_PAUSE_FROM:   r_pause_from <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xbs_pkg::ST_IDLE;
            r_phase     <= xbs_pkg::PH_COLLECT;
            r_fill      <= '0;
            r_seq       <= xbs_pkg::SEQ_START;
            r_sum       <= '0;
            r_att       <= '0;
            r_bcons     <= 1'b0;
            r_wcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_seq       <= n_seq;
            r_sum       <= n_sum;
            r_att       <= n_att;
            r_bcons     <= n_bcons;
            r_wcnt      <= n_wcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tx_word  <= n_tx_word;
        r_tx_count <= n_tx_count;
        r_pause    <= n_pause;
        r_cv       <= n_cv;
        r_cb       <= n_cb;
        r_status   <= n_status;
        r_last     <= n_last;
    end

    always_comb begin
        logic [7:0]    link;
        logic [7:0]    att_inc;
        logic [FW-1:0] fill_inc;
        logic          single;

        n_state     = r_state;
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_seq       = r_seq;
        n_sum       = r_sum;
        n_att       = r_att;
        n_bcons     = r_bcons;
        n_wcnt      = r_wcnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_tx_word   = r_tx_word;
        n_tx_count  = r_tx_count;
        n_pause     = r_pause;
        n_cv        = r_cv;
        n_cb        = r_cb;
        n_status    = r_status;
        n_last      = r_last;
        mem_we      = 1'b0;
        single      = 1'b0;

        link     = (i_req.command == xbs_pkg::CMD_TIMEOUT) ? xbs_pkg::BYTE_NAK
                                                           : i_req.link_byte;
        att_inc  = r_att + 8'd1;
        fill_inc = r_fill + FW'(1);

        unique case (r_state)
            xbs_pkg::ST_IDLE: begin
                if (acc) begin
                    // default single result, adjusted below
                    single     = 1'b1;
                    n_tx_word  = '0;
                    n_tx_count = '0;
                    n_pause    = 1'b0;
                    n_cv       = 1'b0;
                    n_cb       = '0;
                    n_status   = xbs_pkg::STAT_IGNORED;
                    n_last     = 1'b1;
                    if (i_req.command == xbs_pkg::CMD_PAYLOAD) begin
                        if (r_phase == xbs_pkg::PH_COLLECT &&
                            r_fill != FW'(BLOCK_BYTES)) begin
                            mem_we = 1'b1;
                            n_fill = fill_inc;
                            n_sum  = r_sum + i_req.payload_byte;
                            if (fill_inc == FW'(BLOCK_BYTES) || i_req.section_end) begin
                                n_bcons = i_req.section_end && i_req.console_mode;
                                n_att   = '0;
                                n_phase = xbs_pkg::PH_WAIT_BLOCK;
                                n_wcnt  = '0;
                                n_state = xbs_pkg::ST_READ;
                                single  = 1'b0;
                            end else begin
                                n_status = xbs_pkg::STAT_WORKING;
                            end
                        end
                    end else if (i_req.command == xbs_pkg::CMD_FINISH) begin
                        if (r_phase == xbs_pkg::PH_COLLECT && r_fill == '0) begin
                            n_att      = '0;
                            n_phase    = xbs_pkg::PH_WAIT_EOT;
                            n_tx_word  = {24'd0, xbs_pkg::BYTE_EOT};
                            n_tx_count = 3'd1;
                            n_pause    = (r_pause_from == 8'd0);
                            n_status   = xbs_pkg::STAT_WORKING;
                        end
                    end else if (r_phase != xbs_pkg::PH_COLLECT) begin
                        if (link == xbs_pkg::BYTE_ACK) begin
                            if (r_phase == xbs_pkg::PH_WAIT_EOT) begin
                                n_seq    = xbs_pkg::SEQ_START;
                                n_status = xbs_pkg::STAT_FINISHED;
                            end else begin
                                n_seq    = r_seq + 8'd1;
                                n_status = xbs_pkg::STAT_ACKED;
                            end
                            n_fill  = '0;
                            n_sum   = '0;
                            n_att   = '0;
                            n_bcons = 1'b0;
                            n_phase = xbs_pkg::PH_COLLECT;
                        end else if (r_phase == xbs_pkg::PH_WAIT_BLOCK && r_bcons &&
                                     link != xbs_pkg::BYTE_NAK) begin
                            // pass the reply to the console, no resend
                            n_cv     = 1'b1;
                            n_cb     = link;
                            n_status = xbs_pkg::STAT_WORKING;
                        end else if (att_inc >= r_max_att) begin
                            n_status = (link == xbs_pkg::BYTE_NAK) ? xbs_pkg::STAT_REJECTED
                                                                   : xbs_pkg::STAT_NO_RESP;
                            n_fill   = '0;
                            n_seq    = xbs_pkg::SEQ_START;
                            n_sum    = '0;
                            n_att    = '0;
                            n_bcons  = 1'b0;
                            n_phase  = xbs_pkg::PH_COLLECT;
                        end else begin
                            n_att = att_inc;
                            if (r_phase == xbs_pkg::PH_WAIT_EOT) begin
                                n_tx_word  = {24'd0, xbs_pkg::BYTE_EOT};
                                n_tx_count = 3'd1;
                                n_pause    = (att_inc >= r_pause_from);
                                n_status   = xbs_pkg::STAT_WORKING;
                            end else begin
                                n_wcnt  = '0;
                                n_state = xbs_pkg::ST_READ;
                                single  = 1'b0;
                            end
                        end
                    end
                    if (single) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            xbs_pkg::ST_READ: begin
                n_state = xbs_pkg::ST_SEND;
            end
            xbs_pkg::ST_SEND: begin
                // hold the read word until the output register frees up
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_tx_word   = frame_word;
                    n_cv        = 1'b0;
                    n_cb        = '0;
                    n_status    = xbs_pkg::STAT_WORKING;
                    n_pause     = (r_wcnt == '0) && (r_att >= r_pause_from);
                    if (r_wcnt == AW'(WORDS - 1)) begin
                        n_tx_count = 3'(CNT_LAST);
                        n_last     = 1'b1;
                        n_state    = xbs_pkg::ST_IDLE;
                    end else begin
                        n_tx_count = 3'd4;
                        n_last     = 1'b0;
                        n_wcnt     = r_wcnt + AW'(1);
                        n_state    = xbs_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = xbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.tx_word       = r_tx_word;
    assign o_res.tx_count      = r_tx_count;
    assign o_res.pause_before  = r_pause;
    assign o_res.console_valid = r_cv;
    assign o_res.console_byte  = r_cb;
    assign o_res.status        = r_status;
    assign o_res.last          = r_last;

endmodule
